@@ rtl/cvu_pkg.sv @@
// Shared types and constants for the CORDIC trig and vector unit.
// Holds the request/response transaction structs, operation codes and the arctangent table.
// No dependencies.
package cvu_pkg;

	localparam logic [2:0] OP_ROTATE = 3'd0;
	localparam logic [2:0] OP_UNIT   = 3'd1;
	localparam logic [2:0] OP_SIN    = 3'd2;
	localparam logic [2:0] OP_TAN    = 3'd3;
	localparam logic [2:0] OP_POLAR  = 3'd4;
	localparam logic [2:0] OP_LENGTH = 3'd5;
	localparam logic [2:0] OP_ATAN2  = 3'd6;

	// CORDIC shrink factor, 0.32 fixed point, and the unit start vector derived from it
	localparam logic [31:0] TRIG_SCALE = 32'hDBD95B16;
	localparam logic [31:0] UNIT_X     = 32'h00DBD95B;

	// angles in 16.16 degrees
	localparam logic signed [31:0] DEG45  = 32'sd2949120;
	localparam logic signed [31:0] DEG45N = -32'sd2949120;
	localparam logic signed [31:0] DEG90  = 32'sd5898240;
	localparam logic signed [31:0] DEG90N = -32'sd5898240;
	localparam logic signed [31:0] DEG180 = 32'sd11796480;
	localparam logic signed [31:0] DEG180N = -32'sd11796480;

	localparam logic [4:0]  SAFE_MSB = 5'd29;
	// floor(n / 45) = (n * RECIP45) >> 21 for n below 2^15
	localparam logic [15:0] RECIP45  = 16'd46604;
	localparam int          DIV_STEPS = 31;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] angle_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_a;
		logic signed [31:0] result_b;
		logic               zero_vector;
	} rsp_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	// atan(2^-(idx+1)) in 16.16 degrees
	function automatic logic [20:0] atan_deg(input logic [4:0] idx);
		logic [20:0] r;
		case (idx)
			5'd0:    r = 21'd1740967;
			5'd1:    r = 21'd919879;
			5'd2:    r = 21'd466945;
			5'd3:    r = 21'd234379;
			5'd4:    r = 21'd117304;
			5'd5:    r = 21'd58666;
			5'd6:    r = 21'd29335;
			5'd7:    r = 21'd14668;
			5'd8:    r = 21'd7334;
			5'd9:    r = 21'd3667;
			5'd10:   r = 21'd1833;
			5'd11:   r = 21'd917;
			5'd12:   r = 21'd458;
			5'd13:   r = 21'd229;
			5'd14:   r = 21'd115;
			5'd15:   r = 21'd57;
			5'd16:   r = 21'd29;
			5'd17:   r = 21'd14;
			5'd18:   r = 21'd7;
			5'd19:   r = 21'd4;
			5'd20:   r = 21'd2;
			5'd21:   r = 21'd1;
			default: r = 21'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/cordic_trig_vector_unit_core.sv @@
// CORDIC trig and vector unit, top level: fully pipelined datapath.
// Depends on cvu_pkg.
//
// Usage:
//  - Request channel (req_valid / req_stall / req) carries one transaction per
//    item: operation, vec_x, vec_y, angle_in. A transaction is taken at a rising
//    edge with req_valid high and req_stall low.
//  - Response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//    transaction per request, in order: result_a, result_b, zero_vector.
//  - The pipeline has three set-up stages (decode, fold reciprocal multiply
//    with prenormalise, quarter-turn removal), one stage per micro-rotation
//    plus the pre-rotation stage, one stage for the shrink-factor multiply,
//    then a 31-stage bit-per-stage divider for tan, with the other results
//    computed alongside it, and the response register.
//  - Throughput is one transaction per cycle unless stalled; the divider
//    stage chain sets the depth, every stage is a few adds or one multiply deep.
//  - When the receiver stalls a valid response the whole pipeline holds and
//    req_stall rises in the same cycle; nothing is dropped or repeated.
//  - Reset (arst_n low) clears all valid bits; data registers are not reset.
//  - There are no configuration registers and no state between transactions.
module cordic_trig_vector_unit_core #(
	parameter int CORDIC_STAGES = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cvu_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cvu_pkg::rsp_t rsp
);
	import cvu_pkg::*;

	localparam int CS  = CORDIC_STAGES;
	localparam int T1  = CS + 5;              // shrink-factor multiply / divider entry
	localparam int LAT = T1 + DIV_STEPS + 1;  // response register

	typedef struct packed {
		logic [2:0]        op;
		logic              norm;     // vector is prenormalised
		logic              vect;     // vectoring CORDIC
		logic              zero;
		logic              direct;   // length along an axis
		logic [31:0]       dval;
		logic signed [5:0] sh;
	} meta_t;

	typedef struct packed {
		meta_t              meta;
		logic [31:0]        x;
		logic [31:0]        y;
		logic signed [31:0] theta;
		logic               fpos;
		logic               fneg;
		logic [14:0]        n;
		logic [4:0]         msb;
	} st1_t;

	typedef struct packed {
		meta_t              meta;
		logic [31:0]        x;
		logic [31:0]        y;
		logic signed [31:0] theta;
		logic               fpos;
		logic               fneg;
		logic [9:0]         k;
	} st2_t;

	typedef struct packed {
		meta_t              meta;
		logic [31:0]        x;
		logic [31:0]        y;
		logic signed [31:0] theta;
		logic [1:0]         quarters;
	} st3_t;

	typedef struct packed {
		meta_t              meta;
		logic [31:0]        x;
		logic [31:0]        y;
		logic signed [31:0] theta;
	} cord_t;

	typedef struct packed {
		meta_t       meta;
		logic [63:0] px;
		logic [63:0] py;
		logic        sx;
		logic        sy;
		logic [31:0] th;
		logic [31:0] ta;
		logic [31:0] tb;
	} t1_t;

	typedef struct packed {
		meta_t       meta;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] th;
		logic [31:0] ta;
		logic [31:0] tb;
	} t2_t;

	typedef struct packed {
		logic [31:0] r;
		logic [30:0] nlow;
		logic [31:0] b;
		logic [30:0] q;
		logic        neg;
		logic        sat;
	} div_t;

	typedef struct packed {
		logic [31:0] ra;
		logic [31:0] rb;
		logic        zf;
		logic        tan;
	} side_t;

	logic [LAT:1] vld_s;
	logic         adv;

	st1_t  st_s1;
	st2_t  st_s2;
	st3_t  st_s3;
	cord_t cord_s [0:CS];
	t1_t   t1_s;
	t2_t   t2_s;
	div_t  div_s  [0:DIV_STEPS];
	side_t side_s [2:DIV_STEPS];
	rsp_t  rsp_s;

	// the whole pipe holds while a response waits
	assign adv       = !(vld_s[LAT] && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = vld_s[LAT];
	assign rsp       = rsp_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], req_valid};
		end
	end

	// ---- stage 1: decode, fold quotient operand, magnitude MSB
	st1_t               a_d;
	logic [31:0]        a_mag;
	logic signed [32:0] a_upos;
	logic signed [32:0] a_uneg;
	logic               a_trig;

	always_comb begin
		a_d = '0;
		a_d.meta.op = req.operation;
		a_trig = (req.operation == OP_UNIT) || (req.operation == OP_SIN) ||
			(req.operation == OP_TAN);
		a_d.meta.vect = (req.operation == OP_POLAR) || (req.operation == OP_LENGTH) ||
			(req.operation == OP_ATAN2);
		a_d.meta.norm = a_d.meta.vect || (req.operation == OP_ROTATE);
		a_d.meta.zero = (req.vec_x == 32'sd0) && (req.vec_y == 32'sd0);
		a_d.meta.direct = (req.operation == OP_LENGTH) && !a_d.meta.zero &&
			((req.vec_x == 32'sd0) || (req.vec_y == 32'sd0));
		a_d.meta.dval = (req.vec_x == 32'sd0) ? mag32(req.vec_y) : mag32(req.vec_x);
		a_d.x = a_trig ? UNIT_X : req.vec_x;
		a_d.y = a_trig ? 32'd0 : req.vec_y;
		a_d.theta = (req.operation == OP_SIN) ? (DEG90 - req.angle_in) : req.angle_in;
		// quarter turns needed to bring the angle into +-45 degrees
		a_upos = {a_d.theta[31], a_d.theta} + {DEG45[31], DEG45} - 33'sd1;
		a_uneg = {DEG45[31], DEG45} - 33'sd1 - {a_d.theta[31], a_d.theta};
		a_d.fpos = !a_d.meta.vect && (a_d.theta > DEG45);
		a_d.fneg = !a_d.meta.vect && (a_d.theta < DEG45N);
		a_d.n = a_d.fpos ? a_upos[31:17] : a_uneg[31:17];
		a_mag = mag32(req.vec_x) | mag32(req.vec_y);
		for (int i = 0; i < 32; i++) begin
			if (a_mag[i]) a_d.msb = 5'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) st_s1 <= a_d;
	end

	// ---- stage 2: quotient by 45 as reciprocal multiply, prenormalise to bit 29
	st2_t        b_d;
	logic [30:0] b_kprod;
	logic [4:0]  b_ls;
	logic [4:0]  b_rs;

	always_comb begin
		b_d.meta  = st_s1.meta;
		b_d.theta = st_s1.theta;
		b_d.fpos  = st_s1.fpos;
		b_d.fneg  = st_s1.fneg;
		b_kprod   = 31'(st_s1.n) * 31'(RECIP45);
		b_d.k     = b_kprod[30:21];
		b_ls      = SAFE_MSB - st_s1.msb;
		b_rs      = st_s1.msb - SAFE_MSB;
		b_d.x     = st_s1.x;
		b_d.y     = st_s1.y;
		b_d.meta.sh = 6'sd0;
		if (st_s1.meta.norm) begin
			if (st_s1.msb <= SAFE_MSB) begin
				b_d.x = st_s1.x << b_ls;
				b_d.y = st_s1.y << b_ls;
				b_d.meta.sh = $signed({1'b0, b_ls});
			end else begin
				b_d.x = $signed(st_s1.x) >>> b_rs;
				b_d.y = $signed(st_s1.y) >>> b_rs;
				b_d.meta.sh = -$signed({1'b0, b_rs});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) st_s2 <= b_d;
	end

	// ---- stage 3: remove whole quarter turns
	st3_t        c_d;
	logic [31:0] c_kd;

	always_comb begin
		c_d.meta = st_s2.meta;
		c_d.x    = st_s2.x;
		c_d.y    = st_s2.y;
		c_kd     = 32'(st_s2.k) * 32'(DEG90);
		if (st_s2.fpos) begin
			c_d.theta    = st_s2.theta - $signed(c_kd);
			c_d.quarters = st_s2.k[1:0];
		end else if (st_s2.fneg) begin
			c_d.theta    = st_s2.theta + $signed(c_kd);
			c_d.quarters = 2'd0 - st_s2.k[1:0];
		end else begin
			c_d.theta    = st_s2.theta;
			c_d.quarters = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) st_s3 <= c_d;
	end

	// ---- pre-rotation: quarter turns, or half-plane fold for vectoring
	cord_t              p_d;
	logic signed [32:0] p_x;
	logic signed [32:0] p_y;

	always_comb begin
		p_d.meta  = st_s3.meta;
		p_d.x     = st_s3.x;
		p_d.y     = st_s3.y;
		p_d.theta = st_s3.theta;
		p_x = {st_s3.x[31], st_s3.x};
		p_y = {st_s3.y[31], st_s3.y};
		if (st_s3.meta.vect) begin
			if (p_y > p_x) begin
				if (p_y > -p_x) begin
					p_d.theta = DEG90;
					p_d.x = st_s3.y;
					p_d.y = 32'd0 - st_s3.x;
				end else begin
					p_d.theta = (p_y > 33'sd0) ? DEG180 : DEG180N;
					p_d.x = 32'd0 - st_s3.x;
					p_d.y = 32'd0 - st_s3.y;
				end
			end else if (p_y < -p_x) begin
				p_d.theta = DEG90N;
				p_d.x = 32'd0 - st_s3.y;
				p_d.y = st_s3.x;
			end else begin
				p_d.theta = 32'sd0;
			end
		end else begin
			case (st_s3.quarters)
				2'd1: begin
					p_d.x = 32'd0 - st_s3.y;
					p_d.y = st_s3.x;
				end
				2'd2: begin
					p_d.x = 32'd0 - st_s3.x;
					p_d.y = 32'd0 - st_s3.y;
				end
				2'd3: begin
					p_d.x = st_s3.y;
					p_d.y = 32'd0 - st_s3.x;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) cord_s[0] <= p_d;
	end

	// ---- micro-rotations, one per stage
	for (genvar i = 1; i <= CS; i++) begin : g_cord
		localparam logic [31:0] BIAS = 32'd1 << (i - 1);
		cord_t       r_d;
		logic [31:0] v1;
		logic [31:0] v2;
		logic [31:0] at;
		logic        dir;

		always_comb begin
			r_d  = cord_s[i-1];
			v1   = $signed(cord_s[i-1].y + BIAS) >>> i;
			v2   = $signed(cord_s[i-1].x + BIAS) >>> i;
			at   = {11'd0, atan_deg(5'(i - 1))};
			dir  = cord_s[i-1].meta.vect ? ($signed(cord_s[i-1].y) > 32'sd0)
				: (cord_s[i-1].theta < 32'sd0);
			if (dir) begin
				r_d.x     = cord_s[i-1].x + v1;
				r_d.y     = cord_s[i-1].y - v2;
				r_d.theta = cord_s[i-1].theta + $signed(at);
			end else begin
				r_d.x     = cord_s[i-1].x - v1;
				r_d.y     = cord_s[i-1].y + v2;
				r_d.theta = cord_s[i-1].theta - $signed(at);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) cord_s[i] <= r_d;
		end
	end

	// ---- shrink-factor multiply, angle rounding, tan divider set-up
	t1_t         e_d;
	div_t        e_div;
	logic [31:0] e_th;
	logic [31:0] e_nth;
	logic [31:0] e_am;
	logic [31:0] e_bm;
	logic [48:0] e_num;

	always_comb begin
		e_d.meta = cord_s[CS].meta;
		e_d.sx   = cord_s[CS].x[31];
		e_d.sy   = cord_s[CS].y[31];
		e_d.px   = 64'(mag32(cord_s[CS].x)) * 64'(TRIG_SCALE);
		e_d.py   = 64'(mag32(cord_s[CS].y)) * 64'(TRIG_SCALE);
		// angle rounded to a multiple of 32, half away from zero
		e_th     = cord_s[CS].theta;
		e_nth    = 32'd0 - e_th;
		if (!cord_s[CS].theta[31]) e_d.th = (e_th + 32'd16) & ~32'd31;
		else e_d.th = 32'd0 - ((e_nth + 32'd16) & ~32'd31);
		e_d.ta   = $signed(cord_s[CS].x + 32'h80) >>> 8;
		e_d.tb   = $signed(cord_s[CS].y + 32'h80) >>> 8;

		e_am = mag32(cord_s[CS].y);
		e_bm = mag32(cord_s[CS].x);
		e_num = {1'b0, e_am, 16'd0} + 49'(e_bm >> 1);
		e_div.neg  = cord_s[CS].x[31] ^ cord_s[CS].y[31];
		e_div.b    = e_bm;
		e_div.r    = {14'd0, e_num[48:31]};
		e_div.nlow = e_num[30:0];
		e_div.q    = '0;
		e_div.sat  = (e_bm == 32'd0) || ({14'd0, e_num[48:31]} >= e_bm);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s     <= e_d;
			div_s[0] <= e_div;
		end
	end

	// ---- restoring divider, one quotient bit per stage
	for (genvar d = 1; d <= DIV_STEPS; d++) begin : g_div
		localparam int J = DIV_STEPS - d;
		div_t        v_d;
		logic [32:0] t;

		always_comb begin
			v_d = div_s[d-1];
			t   = {div_s[d-1].r, div_s[d-1].nlow[J]};
			if (t >= {1'b0, div_s[d-1].b}) begin
				v_d.r    = 32'(t - {1'b0, div_s[d-1].b});
				v_d.q[J] = 1'b1;
			end else begin
				v_d.r = t[31:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) div_s[d] <= v_d;
		end
	end

	// ---- shrink-factor rounding and sign
	t2_t         f_d;
	logic [31:0] f_rx;
	logic [31:0] f_ry;

	always_comb begin
		f_d.meta = t1_s.meta;
		f_d.th   = t1_s.th;
		f_d.ta   = t1_s.ta;
		f_d.tb   = t1_s.tb;
		f_rx     = t1_s.px[63:32] + 32'd1;
		f_ry     = t1_s.py[63:32] + 32'd1;
		f_d.dx   = t1_s.sx ? (32'd0 - f_rx) : f_rx;
		f_d.dy   = t1_s.sy ? (32'd0 - f_ry) : f_ry;
	end

	always_ff @(posedge clk) begin
		if (adv) t2_s <= f_d;
	end

	// ---- rescale by the prenormalise shift and pick results
	side_t       g_d;
	logic        g_shp;
	logic [4:0]  g_sr;
	logic [4:0]  g_sl;
	logic [31:0] g_half;
	logic [31:0] g_rota;
	logic [31:0] g_rotb;
	logic [31:0] g_pola;
	logic [31:0] g_lena;
	logic [5:0]  g_nsh;

	always_comb begin
		g_shp  = !t2_s.meta.sh[5] && (t2_s.meta.sh != 6'sd0);
		g_sr   = t2_s.meta.sh[4:0];
		g_nsh  = 6'd0 - t2_s.meta.sh;
		g_sl   = g_nsh[4:0];
		g_half = 32'd1 << (g_sr - 5'd1);
		if (g_shp) begin
			g_rota = $signed(t2_s.dx + g_half - {31'd0, t2_s.dx[31]}) >>> g_sr;
			g_rotb = $signed(t2_s.dy + g_half - {31'd0, t2_s.dy[31]}) >>> g_sr;
			g_lena = $signed(t2_s.dx + g_half) >>> g_sr;
		end else begin
			g_rota = t2_s.dx << g_sl;
			g_rotb = t2_s.dy << g_sl;
			g_lena = t2_s.dx << g_sl;
		end
		g_pola = t2_s.meta.sh[5] ? (t2_s.dx << g_sl) : ($signed(t2_s.dx) >>> g_sr);

		g_d.ra  = '0;
		g_d.rb  = '0;
		g_d.zf  = 1'b0;
		g_d.tan = (t2_s.meta.op == OP_TAN);
		case (t2_s.meta.op)
			OP_ROTATE: begin
				g_d.ra = g_rota;
				g_d.rb = g_rotb;
			end
			OP_UNIT: begin
				g_d.ra = t2_s.ta;
				g_d.rb = t2_s.tb;
			end
			OP_SIN:    g_d.ra = t2_s.ta;
			OP_POLAR: begin
				g_d.ra = g_pola;
				g_d.rb = t2_s.th;
			end
			OP_LENGTH: g_d.ra = g_lena;
			OP_ATAN2:  g_d.ra = t2_s.th;
			default: ;
		endcase
		if (t2_s.meta.norm && t2_s.meta.zero) begin
			g_d.ra = '0;
			g_d.rb = '0;
			g_d.zf = 1'b1;
		end else if (t2_s.meta.direct) begin
			g_d.ra = t2_s.meta.dval;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) side_s[2] <= g_d;
	end

	for (genvar d = 3; d <= DIV_STEPS; d++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) side_s[d] <= side_s[d-1];
		end
	end

	// ---- response: tan quotient with saturation and sign
	rsp_t        h_d;
	logic [31:0] h_q;

	always_comb begin
		h_q = div_s[DIV_STEPS].sat ? 32'h7FFFFFFF : {1'b0, div_s[DIV_STEPS].q};
		h_d.result_a = side_s[DIV_STEPS].tan
			? (div_s[DIV_STEPS].neg ? (32'd0 - h_q) : h_q)
			: side_s[DIV_STEPS].ra;
		h_d.result_b    = side_s[DIV_STEPS].rb;
		h_d.zero_vector = side_s[DIV_STEPS].zf;
	end

	always_ff @(posedge clk) begin
		if (adv) rsp_s <= h_d;
	end

`ifndef SYNTH
	a_hold_upstream: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response stalled");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.zero_vector |-> rsp.result_a == 32'sd0 && rsp.result_b == 32'sd0)
		else $error("zero vector flag with nonzero result");

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[3] |=> vld_s[4])
		else $error("transaction lost entering CORDIC stages");

	a_angle_round: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[T1+1] && t2_s.meta.vect |-> t2_s.th[4:0] == 5'd0)
		else $error("polar angle not rounded");
`endif

endmodule

@@ tb/sv/tb_cordic_trig_vector_unit_core.sv @@
// Self-checking testbench for cordic_trig_vector_unit_core.
// Depends on cvu_pkg and the core; it holds its own bit-exact predictor of the CORDIC datapath.
// Directed corner cases come first, then random traffic in three stall/idle phases.
module tb_cordic_trig_vector_unit_core;
	import cvu_pkg::*;

	// scoreboard: predicts one response per accepted request and checks them in order
	class cordic_scoreboard;
		rsp_t   pending[$];
		int     errors;
		int     n_req;
		int     n_rsp;
		int     n_zero;
		longint q45  = 64'sd2949120;
		longint q90  = 64'sd5898240;
		longint q180 = 64'sd11796480;
		int     atan_lut[22] = '{1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

		function logic [31:0] sra(logic [31:0] v, int s);
			return $signed(v) >>> (s & 31);
		endfunction

		function longint sx(logic [31:0] v);
			return longint'($signed(v));
		endfunction

		function logic [31:0] magn(logic [31:0] v);
			return v[31] ? 32'd0 - v : v;
		endfunction

		// bring the top magnitude bit to bit 29; returns the left shift applied
		function int normalise(ref logic [31:0] x, ref logic [31:0] y);
			logic [31:0] m;
			int top;
			m = magn(x) | magn(y);
			top = 0;
			for (int i = 31; i >= 0; i--)
				if (m[i] && top == 0 && (m >> (i + 1)) == 0) top = i;
			if (top <= 29) begin
				x = x << (29 - top);
				y = y << (29 - top);
			end else begin
				x = sra(x, top - 29);
				y = sra(y, top - 29);
			end
			return 29 - top;
		endfunction

		function logic [31:0] shrink(logic [31:0] v);
			logic [63:0] p;
			logic [31:0] r;
			p = 64'(magn(v)) * 64'h00000000DBD95B16 + 64'h0000000100000000;
			r = p[63:32];
			return v[31] ? 32'd0 - r : r;
		endfunction

		function void rotate(ref logic [31:0] x, ref logic [31:0] y, input longint theta);
			longint k;
			int turns;
			logic [31:0] t, b, v1, v2;
			turns = 0;
			if (theta < -q45) begin
				k = (-q45 - theta + q90 - 1) / q90;
				theta += k * q90;
				turns = (4 - int'(k % 4)) & 3;
			end else if (theta > q45) begin
				k = (theta - q45 + q90 - 1) / q90;
				theta -= k * q90;
				turns = int'(k % 4);
			end
			for (int q = 0; q < turns; q++) begin
				t = 32'd0 - y;
				y = x;
				x = t;
			end
			for (int i = 1; i <= 22; i++) begin
				b = 32'd1 << (i - 1);
				v1 = sra(y + b, i);
				v2 = sra(x + b, i);
				if (theta < 0) begin
					x += v1; y -= v2; theta += atan_lut[i-1];
				end else begin
					x -= v1; y += v2; theta -= atan_lut[i-1];
				end
			end
		endfunction

		// vectoring mode: x becomes scaled length, returns the rounded angle
		function logic [31:0] vectorise(ref logic [31:0] x, input logic [31:0] y);
			longint vx, vy, theta;
			logic [31:0] t, b, v1, v2;
			vx = sx(x);
			vy = sx(y);
			if (vy > vx) begin
				if (vy > -vx) begin
					theta = q90; t = y; y = 32'd0 - x; x = t;
				end else begin
					theta = (vy > 0) ? q180 : -q180; x = 32'd0 - x; y = 32'd0 - y;
				end
			end else if (vy < -vx) begin
				theta = -q90; t = 32'd0 - y; y = x; x = t;
			end else begin
				theta = 0;
			end
			for (int i = 1; i <= 22; i++) begin
				b = 32'd1 << (i - 1);
				v1 = sra(y + b, i);
				v2 = sra(x + b, i);
				if (sx(y) > 0) begin
					x += v1; y -= v2; theta += atan_lut[i-1];
				end else begin
					x -= v1; y += v2; theta -= atan_lut[i-1];
				end
			end
			if (theta >= 0) theta = (theta + 16) & ~64'sd31;
			else theta = -((-theta + 16) & ~64'sd31);
			return theta[31:0];
		endfunction

		function logic [31:0] tan_quot(logic [31:0] num, logic [31:0] den);
			logic [63:0] a, b, q;
			a = 64'(magn(num));
			b = 64'(magn(den));
			if (b == 0) q = 64'h7FFFFFFF;
			else begin
				q = ((a << 16) + (b >> 1)) / b;
				if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
			end
			return (num[31] ^ den[31]) ? 32'd0 - q[31:0] : q[31:0];
		endfunction

		function rsp_t predict(req_t r);
			logic [31:0] x, y, ang, ra, rb, vx, vy, th, half;
			int sh;
			rsp_t o;
			x = r.vec_x; y = r.vec_y; ang = r.angle_in;
			ra = 0; rb = 0;
			o.zero_vector = 1'b0;
			if (r.operation inside {OP_UNIT, OP_SIN, OP_TAN}) begin
				vx = UNIT_X; vy = 0;
				rotate(vx, vy, sx(r.operation == OP_SIN ? 32'd5898240 - ang : ang));
				if (r.operation == OP_TAN) ra = tan_quot(vy, vx);
				else begin
					ra = sra(vx + 32'h80, 8);
					if (r.operation == OP_UNIT) rb = sra(vy + 32'h80, 8);
				end
			end else if (r.operation inside {OP_ROTATE, OP_POLAR, OP_LENGTH, OP_ATAN2}) begin
				if (x == 0 && y == 0) o.zero_vector = 1'b1;
				else if (r.operation == OP_LENGTH && x == 0) ra = magn(y);
				else if (r.operation == OP_LENGTH && y == 0) ra = magn(x);
				else if (r.operation == OP_ROTATE) begin
					sh = normalise(x, y);
					rotate(x, y, sx(ang));
					x = shrink(x);
					y = shrink(y);
					if (sh > 0) begin
						half = 32'd1 << (sh - 1);
						ra = sra(x + half - (x >> 31), sh);
						rb = sra(y + half - (y >> 31), sh);
					end else begin
						ra = x << (-sh);
						rb = y << (-sh);
					end
				end else begin
					sh = normalise(x, y);
					th = vectorise(x, y);
					if (r.operation == OP_ATAN2) ra = th;
					else begin
						x = shrink(x);
						if (r.operation == OP_POLAR) begin
							ra = (sh >= 0) ? sra(x, sh) : x << (-sh);
							rb = th;
						end else
							ra = (sh > 0) ? sra(x + (32'd1 << (sh - 1)), sh) : x << (-sh);
					end
				end
			end
			o.result_a = ra;
			o.result_b = rb;
			return o;
		endfunction

		function void note_request(req_t r);
			n_req++;
			pending.push_back(predict(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			n_rsp++;
			if (got.zero_vector) n_zero++;
			if (pending.size() == 0) begin
				$error("response with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.result_a !== want.result_a) begin
				$error("result_a expected %h actual %h", want.result_a, got.result_a);
				errors++;
			end
			if (got.result_b !== want.result_b) begin
				$error("result_b expected %h actual %h", want.result_b, got.result_b);
				errors++;
			end
			if (got.zero_vector !== want.zero_vector) begin
				$error("zero_vector expected %b actual %b", want.zero_vector, got.zero_vector);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// idle percentages for the sender and the receiver, changed per phase
	int send_idle = 0;
	int recv_idle = 0;

	cordic_scoreboard sb = new();

	cordic_trig_vector_unit_core DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle);
	end

	// both channels sampled at the rising edge, before the DUT's registers update
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall) sb.check_response(rsp);
	end

	// present one transaction, possibly after random idle cycles; hold until taken
	task automatic send_trans(req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_op(logic [2:0] op, int x, int y, int a);
		req_t r;
		r.operation = op;
		r.vec_x = x;
		r.vec_y = y;
		r.angle_in = a;
		send_trans(r);
	endtask

	task automatic drain;
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// component value: a mix of full range, scaled down, zero and extremes
	function automatic logic [31:0] rand_comp();
		logic [31:0] v;
		case ($urandom_range(5))
			0, 1: v = $urandom;
			2: v = $signed($urandom) >>> $urandom_range(31);
			3: v = $urandom_range(8) - 4;
			4: v = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000001;
			default: v = 0;
		endcase
		if (v == 32'h80000000) v = 32'h80000001;
		return v;
	endfunction

	function automatic logic [31:0] rand_angle();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(32'd47185920) - 32'd23592960; // within +-360 degrees
			2: v = ($urandom_range(16) - 8) * 32'd5898240 + ($urandom_range(4) - 2);
			default: v = $urandom_range(32'd5898240);
		endcase
		if (v == 32'h80000000) v = 32'h80000001;
		return v;
	endfunction

	task automatic random_phase(int n, int s_idle, int r_idle);
		req_t r;
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < n; i++) begin
			r.operation = $urandom_range(6);
			r.vec_x = rand_comp();
			r.vec_y = rand_comp();
			r.angle_in = rand_angle();
			send_trans(r);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corners, no idling
		send_op(OP_ROTATE, 1, 0, 32'h005A0000);
		send_op(OP_ROTATE, 32'h7FFFFFFF, 32'h7FFFFFFF, -32'h002D0000);
		send_op(OP_ROTATE, 32'h80000001, 5, 32'h7FFFFFFF);
		send_op(OP_ROTATE, 0, 0, 32'h00100000);                   // zero vector
		send_op(OP_UNIT, 0, 0, 0);
		send_op(OP_UNIT, 0, 0, 32'h00B40000);
		send_op(OP_UNIT, 0, 0, -32'h00B40000);
		send_op(OP_UNIT, 0, 0, 32'h80000001);                     // extreme angles
		send_op(OP_SIN, 0, 0, 32'h001E0000);
		send_op(OP_SIN, 0, 0, 32'h7FFFFFFF);                      // 90 minus angle lands near the negative limit
		send_op(OP_TAN, 0, 0, 32'h005A0000);                      // cosine reaches zero
		send_op(OP_TAN, 0, 0, -32'h005A0000);
		send_op(OP_TAN, 0, 0, 32'h0059FFFF);                      // quotient saturates
		send_op(OP_TAN, 0, 0, 32'h002D0000);
		send_op(OP_POLAR, 0, 0, 0);
		send_op(OP_POLAR, 32'h7FFFFFFF, 32'h80000001, 0);
		send_op(OP_POLAR, -7, 1, 0);
		send_op(OP_LENGTH, 3, 4, 0);
		send_op(OP_LENGTH, 0, 32'h80000001, 0);                   // on an axis
		send_op(OP_LENGTH, 32'h7FFFFFFF, 0, 0);
		send_op(OP_LENGTH, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_op(OP_ATAN2, -1, 0, 0);
		send_op(OP_ATAN2, 0, -1, 0);
		send_op(OP_ATAN2, 0, 0, 0);
		send_op(3'd7, 32'h7FFFFFFF, 32'h80000001, 32'hFFFFFFFF); // unused code
		drain(); // sender holds off until every response is back

		random_phase(350, 29, 83);
		random_phase(350, 83, 29);
		random_phase(350, 0, 0);
		drain();
		recv_idle = 0;
		repeat (80) @(posedge clk);

		$display("covered %0d requests and %0d responses across all seven operations,",
			sb.n_req, sb.n_rsp);
		$display("with %0d zero-vector cases and three idle/stall mixes", sb.n_zero);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

endmodule
